/* hw/rtl/vol_grid_bilinear_interp_macros.svh */
// Assertion helpers for the volatility grid block.
// Both expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef VOL_GRID_BILINEAR_INTERP_MACROS_SVH
`define VOL_GRID_BILINEAR_INTERP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define VGBI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Antecedent this cycle implies consequent on the next cycle.
`define VGBI_ASSERT_NEXT(lbl, ante, cons, msg) \
    `VGBI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hw/rtl/vgbi_pkg.sv */
// ----------------------------------------------------------------------------
// vgbi_pkg: shared types and constants
// Function codes, register indexes, sequencer states and fixed-point constants
// for the volatility grid block.
// ----------------------------------------------------------------------------
package vgbi_pkg;

    localparam logic [2:0] FUNC_LOAD_STRIKE   = 3'd0;
    localparam logic [2:0] FUNC_LOAD_MATURITY = 3'd1;
    localparam logic [2:0] FUNC_LOAD_VOL      = 3'd2;
    localparam logic [2:0] FUNC_QUERY         = 3'd3;
    localparam logic [2:0] FUNC_CHECK         = 3'd4;

    localparam logic CFG_STRIKE_COUNT   = 1'b0;
    localparam logic CFG_MATURITY_COUNT = 1'b1;

    // Q1.16 unity weight
    localparam logic [16:0] WONE = 17'h1_0000;
    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CLAMP_HI,
        ST_CLAMP_LO,
        ST_SCAN,
        ST_WSETUP,
        ST_DIV,
        ST_CORNER_RD,
        ST_CORNER_MUL,
        ST_CORNER_ACC,
        ST_VOL,
        ST_CK_RD,
        ST_CK_LD,
        ST_VV,
        ST_MT,
        ST_FIN
    } state_t;

endpackage

/* hw/rtl/vol_grid_bilinear_interp.sv */
// A query's result waits on the node scans over the single-read node memories, up to two
// 16-step serial divisions and four corner MACs; a check's waits on the grid walk over up
// to ns*nm grid entries. Loads are taken in the idle state and give no result. One item at
// a time: no new beat is taken until the last item is through; a finished result sits in
// the output register while further beats are taken.
// Reset (synchronous, active low) clears control, sets both counts to 2; memories kept.
`include "vol_grid_bilinear_interp_macros.svh"
// ----------------------------------------------------------------------------
// vol_grid_bilinear_interp
// Node lists and volatility grid in memories; sequencer for bilinear lookup,
// total variance and calendar check.
// ----------------------------------------------------------------------------
module vol_grid_bilinear_interp #(
    parameter int MAX_STRIKES    = 64,
    parameter int MAX_MATURITIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: strike_index[5:0], maturity_index[10:6], node_value[42:11],
    //        query_strike[74:43], query_maturity[106:75], zero pad
    input  logic [vgbi_pkg::IN_TDATA_W-1:0] s_tdata,
    // tuser: func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: implied_vol[31:0], total_variance[63:32], arbitrage_free[64],
    //        bad_strike[70:65], zero pad
    output logic [vgbi_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int SAW = $clog2(MAX_STRIKES);
    localparam int MAW = $clog2(MAX_MATURITIES);
    localparam int SNW = $clog2(MAX_STRIKES + 1);
    localparam int MNW = $clog2(MAX_MATURITIES + 1);
    localparam int KW  = (SNW > MNW) ? SNW : MNW;
    localparam int SCW = (SNW > 7) ? SNW : 7;
    localparam int MCW = (MNW > 6) ? MNW : 6;
    localparam int GAW = SAW + MAW;

    // input fields
    logic [2:0]  in_func;
    logic [5:0]  in_si;
    logic [4:0]  in_mi;
    logic [31:0] in_val, in_qk, in_qt;
    assign in_func = s_tuser;
    assign in_si   = s_tdata[5:0];
    assign in_mi   = s_tdata[10:6];
    assign in_val  = s_tdata[42:11];
    assign in_qk   = s_tdata[74:43];
    assign in_qt   = s_tdata[106:75];

    vgbi_pkg::state_t state_reg, state_next;

    logic [6:0]  strike_count_reg;
    logic [5:0]  maturity_count_reg;
    logic        dim_reg, mode_check_reg;
    logic [31:0] x_reg, lo_reg, hi_reg, qt_reg;
    logic [KW-1:0] k_reg;
    logic [SAW-1:0] i1_reg, i_reg;
    logic [MAW-1:0] j1_reg, j_reg;
    logic [16:0] wk_reg, wt_reg;
    logic [31:0] rem_reg, div_reg;
    logic [15:0] q_reg;
    logic [3:0]  dcnt_reg;
    logic [1:0]  cn_reg;
    logic [32:0] pw_reg;
    logic [63:0] prod_reg, acc_reg;
    logic [31:0] v_op_reg, t_op_reg, prev_reg;
    logic [63:0] vv_reg, m1_reg, m2_reg;
    logic        m_tvalid_reg;
    logic [vgbi_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // memories
    logic [31:0] str_mem [MAX_STRIKES];
    logic [31:0] mat_mem [MAX_MATURITIES];
    logic [31:0] grid_mem [2**GAW];
    logic [31:0] str_q, mat_q, grid_q;
    logic        str_we, mat_we, grid_we;
    logic [KW-1:0]  node_raddr;
    logic [GAW-1:0] grid_raddr;

    // clamped counts
    logic [SCW-1:0] ns_wide;
    logic [MCW-1:0] nm_wide;
    logic [SNW-1:0] ns;
    logic [MNW-1:0] nm;
    logic [KW-1:0]  n_sel;

    always_comb begin
        if (SCW'(strike_count_reg) < SCW'(2)) begin
            ns_wide = SCW'(2);
        end else if (SCW'(strike_count_reg) > SCW'(MAX_STRIKES)) begin
            ns_wide = SCW'(MAX_STRIKES);
        end else begin
            ns_wide = SCW'(strike_count_reg);
        end
        if (MCW'(maturity_count_reg) < MCW'(2)) begin
            nm_wide = MCW'(2);
        end else if (MCW'(maturity_count_reg) > MCW'(MAX_MATURITIES)) begin
            nm_wide = MCW'(MAX_MATURITIES);
        end else begin
            nm_wide = MCW'(maturity_count_reg);
        end
    end
    assign ns    = ns_wide[SNW-1:0];
    assign nm    = nm_wide[MNW-1:0];
    assign n_sel = dim_reg ? KW'(nm) : KW'(ns);

    logic in_acc;
    logic si_ok, mi_ok;
    assign in_acc = s_tvalid && s_tready;
    assign si_ok  = SCW'(in_si) < SCW'(MAX_STRIKES);
    assign mi_ok  = MCW'(in_mi) < MCW'(MAX_MATURITIES);

    logic [31:0] node_q;
    assign node_q = dim_reg ? mat_q : str_q;

    // scan and weight helpers
    logic scan_stop, w_special;
    logic [16:0] w_special_val;
    assign scan_stop = (x_reg <= node_q) || (k_reg == n_sel - KW'(1));
    assign w_special = (hi_reg <= lo_reg) || (x_reg <= lo_reg) || (x_reg >= hi_reg);
    assign w_special_val = ((hi_reg <= lo_reg) || (x_reg <= lo_reg)) ? 17'd0
                                                                      : vgbi_pkg::WONE;

    // restoring divider step; remainder stays below the divisor
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [15:0] q_step;
    logic [31:0] rem_step;
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, div_reg};
    assign q_step   = {q_reg[14:0], rem_ge};
    assign rem_step = rem_ge ? 32'(rem_sh - {1'b0, div_reg}) : rem_sh[31:0];

    // corner weights
    logic [16:0] wr, wc;
    logic [33:0] pw_full;
    logic [64:0] prod_full;
    logic [63:0] acc_sum, acc_rnd;
    assign wr        = cn_reg[0] ? wk_reg : 17'(vgbi_pkg::WONE - wk_reg);
    assign wc        = cn_reg[1] ? wt_reg : 17'(vgbi_pkg::WONE - wt_reg);
    assign pw_full   = wr * wc;
    assign prod_full = pw_reg * grid_q;
    assign acc_sum   = acc_reg + prod_reg;
    assign acc_rnd   = acc_reg + vgbi_pkg::ROUND_HALF;

    // variance chain
    logic [63:0] vv_full, m1_full, m2_full;
    logic [64:0] var_sum;
    logic [31:0] var_sat;
    assign vv_full = v_op_reg * v_op_reg;
    assign m1_full = vv_reg[63:32] * t_op_reg;
    assign m2_full = vv_reg[31:0] * t_op_reg;
    assign var_sum = {1'b0, m1_reg} + 65'(m2_reg[63:32]);
    assign var_sat = (|var_sum[64:32]) ? 32'hFFFF_FFFF : var_sum[31:0];

    logic ck_fail, ck_last_col, ck_last_row, fin_emit, out_free, fin_go;
    assign ck_fail     = var_sat < prev_reg;
    assign ck_last_col = MNW'(j_reg) == nm - MNW'(1);
    assign ck_last_row = SNW'(i_reg) == ns - SNW'(1);
    assign fin_emit    = mode_check_reg ? (ck_fail || (ck_last_col && ck_last_row)) : 1'b1;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign fin_go      = !fin_emit || out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vgbi_pkg::ST_IDLE: begin
                if (in_acc && in_func == vgbi_pkg::FUNC_QUERY) begin
                    state_next = vgbi_pkg::ST_START;
                end else if (in_acc && in_func == vgbi_pkg::FUNC_CHECK) begin
                    state_next = vgbi_pkg::ST_CK_RD;
                end
            end
            vgbi_pkg::ST_START:    state_next = vgbi_pkg::ST_CLAMP_HI;
            vgbi_pkg::ST_CLAMP_HI: state_next = vgbi_pkg::ST_CLAMP_LO;
            vgbi_pkg::ST_CLAMP_LO: state_next = vgbi_pkg::ST_SCAN;
            vgbi_pkg::ST_SCAN: begin
                if (scan_stop) begin
                    state_next = vgbi_pkg::ST_WSETUP;
                end
            end
            vgbi_pkg::ST_WSETUP: begin
                if (!w_special) begin
                    state_next = vgbi_pkg::ST_DIV;
                end else if (!dim_reg) begin
                    state_next = vgbi_pkg::ST_START;
                end else begin
                    state_next = vgbi_pkg::ST_CORNER_RD;
                end
            end
            vgbi_pkg::ST_DIV: begin
                if (dcnt_reg == 4'd0) begin
                    state_next = dim_reg ? vgbi_pkg::ST_CORNER_RD : vgbi_pkg::ST_START;
                end
            end
            vgbi_pkg::ST_CORNER_RD:  state_next = vgbi_pkg::ST_CORNER_MUL;
            vgbi_pkg::ST_CORNER_MUL: state_next = vgbi_pkg::ST_CORNER_ACC;
            vgbi_pkg::ST_CORNER_ACC: begin
                state_next = (cn_reg == 2'd3) ? vgbi_pkg::ST_VOL : vgbi_pkg::ST_CORNER_RD;
            end
            vgbi_pkg::ST_VOL:   state_next = vgbi_pkg::ST_VV;
            vgbi_pkg::ST_CK_RD: state_next = vgbi_pkg::ST_CK_LD;
            vgbi_pkg::ST_CK_LD: state_next = vgbi_pkg::ST_VV;
            vgbi_pkg::ST_VV:    state_next = vgbi_pkg::ST_MT;
            vgbi_pkg::ST_MT:    state_next = vgbi_pkg::ST_FIN;
            vgbi_pkg::ST_FIN: begin
                if (fin_go) begin
                    state_next = fin_emit ? vgbi_pkg::ST_IDLE : vgbi_pkg::ST_CK_RD;
                end
            end
            default: state_next = vgbi_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake, memory strobes and addresses
    always_comb begin
        s_tready   = 1'b0;
        str_we     = 1'b0;
        mat_we     = 1'b0;
        grid_we    = 1'b0;
        node_raddr = '0;
        grid_raddr = '0;
        unique case (state_reg)
            vgbi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                str_we   = in_acc && in_func == vgbi_pkg::FUNC_LOAD_STRIKE && si_ok;
                mat_we   = in_acc && in_func == vgbi_pkg::FUNC_LOAD_MATURITY && mi_ok;
                grid_we  = in_acc && in_func == vgbi_pkg::FUNC_LOAD_VOL && si_ok && mi_ok;
            end
            vgbi_pkg::ST_START:    node_raddr = n_sel - KW'(1);
            vgbi_pkg::ST_CLAMP_HI: node_raddr = '0;
            vgbi_pkg::ST_CLAMP_LO: node_raddr = KW'(1);
            vgbi_pkg::ST_SCAN:     node_raddr = k_reg + KW'(1);
            vgbi_pkg::ST_CORNER_RD: begin
                grid_raddr = {SAW'(i1_reg + SAW'(cn_reg[0])), MAW'(j1_reg + MAW'(cn_reg[1]))};
            end
            vgbi_pkg::ST_CK_RD: begin
                node_raddr = KW'(j_reg);
                grid_raddr = {i_reg, j_reg};
            end
            default: ;
        endcase
    end

    // memories, registered read
    always_ff @(posedge aclk) begin
        if (str_we) begin
            str_mem[SAW'(in_si)] <= in_val;
        end
        str_q <= str_mem[node_raddr[SAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (mat_we) begin
            mat_mem[MAW'(in_mi)] <= in_val;
        end
        mat_q <= mat_mem[node_raddr[MAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[{SAW'(in_si), MAW'(in_mi)}] <= in_val;
        end
        grid_q <= grid_mem[grid_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= vgbi_pkg::ST_IDLE;
            strike_count_reg   <= 7'd2;
            maturity_count_reg <= 6'd2;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_addr == vgbi_pkg::CFG_STRIKE_COUNT) begin
                strike_count_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == vgbi_pkg::CFG_MATURITY_COUNT) begin
                maturity_count_reg <= cfg_wdata[5:0];
            end
            if (state_reg == vgbi_pkg::ST_FIN && fin_go && fin_emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            vgbi_pkg::ST_IDLE: begin
                dim_reg        <= 1'b0;
                mode_check_reg <= in_func == vgbi_pkg::FUNC_CHECK;
                x_reg          <= in_qk;
                qt_reg         <= in_qt;
                i_reg          <= '0;
                j_reg          <= '0;
                prev_reg       <= '0;
            end
            vgbi_pkg::ST_CLAMP_HI: begin
                if (x_reg > node_q) begin
                    x_reg <= node_q;
                end
            end
            vgbi_pkg::ST_CLAMP_LO: begin
                if (x_reg < node_q) begin
                    x_reg <= node_q;
                end
                lo_reg <= node_q;
                k_reg  <= KW'(1);
            end
            vgbi_pkg::ST_SCAN: begin
                if (scan_stop) begin
                    hi_reg <= node_q;
                    if (dim_reg) begin
                        j1_reg <= MAW'(k_reg - KW'(1));
                    end else begin
                        i1_reg <= SAW'(k_reg - KW'(1));
                    end
                end else begin
                    lo_reg <= node_q;
                    k_reg  <= k_reg + KW'(1);
                end
            end
            vgbi_pkg::ST_WSETUP: begin
                rem_reg  <= x_reg - lo_reg;
                div_reg  <= hi_reg - lo_reg;
                q_reg    <= '0;
                dcnt_reg <= 4'd15;
                cn_reg   <= '0;
                acc_reg  <= '0;
                if (w_special) begin
                    if (dim_reg) begin
                        wt_reg <= w_special_val;
                    end else begin
                        wk_reg  <= w_special_val;
                        dim_reg <= 1'b1;
                        x_reg   <= qt_reg;
                    end
                end
            end
            vgbi_pkg::ST_DIV: begin
                rem_reg  <= rem_step;
                q_reg    <= q_step;
                dcnt_reg <= dcnt_reg - 4'd1;
                if (dcnt_reg == 4'd0) begin
                    if (dim_reg) begin
                        wt_reg <= {1'b0, q_step};
                    end else begin
                        wk_reg  <= {1'b0, q_step};
                        dim_reg <= 1'b1;
                        x_reg   <= qt_reg;
                    end
                end
            end
            vgbi_pkg::ST_CORNER_RD:  pw_reg   <= pw_full[32:0];
            vgbi_pkg::ST_CORNER_MUL: prod_reg <= prod_full[63:0];
            vgbi_pkg::ST_CORNER_ACC: begin
                acc_reg <= acc_sum;
                cn_reg  <= cn_reg + 2'd1;
            end
            vgbi_pkg::ST_VOL: begin
                v_op_reg <= acc_rnd[63:32];
                t_op_reg <= qt_reg;
            end
            vgbi_pkg::ST_CK_LD: begin
                v_op_reg <= grid_q;
                t_op_reg <= mat_q;
            end
            vgbi_pkg::ST_VV: vv_reg <= vv_full;
            vgbi_pkg::ST_MT: begin
                m1_reg <= m1_full;
                m2_reg <= m2_full;
            end
            vgbi_pkg::ST_FIN: begin
                if (fin_go && mode_check_reg && !fin_emit) begin
                    if (ck_last_col) begin
                        j_reg    <= '0;
                        i_reg    <= i_reg + SAW'(1);
                        prev_reg <= '0;
                    end else begin
                        j_reg    <= j_reg + MAW'(1);
                        prev_reg <= var_sat;
                    end
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == vgbi_pkg::ST_FIN && fin_go && fin_emit) begin
            if (mode_check_reg) begin
                m_tdata_reg <= {1'b0, (ck_fail ? 6'(i_reg) : 6'd0), !ck_fail, 64'd0};
            end else begin
                m_tdata_reg <= {8'd0, var_sat, v_op_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `VGBI_ASSERT(a_div_rem_below_divisor,
        (state_reg == vgbi_pkg::ST_DIV) |-> (rem_reg < div_reg),
        "divider remainder reached the divisor")
    `VGBI_ASSERT(a_scan_in_range,
        (state_reg == vgbi_pkg::ST_SCAN) |-> (k_reg != '0 && k_reg <= n_sel - KW'(1)),
        "node scan index outside the node list")
    `VGBI_ASSERT(a_result_from_fin,
        $rose(m_tvalid_reg) |-> $past(state_reg == vgbi_pkg::ST_FIN),
        "result raised outside the finish step")
    `VGBI_ASSERT_NEXT(a_query_starts_on_strikes,
        in_acc && in_func == vgbi_pkg::FUNC_QUERY,
        state_reg == vgbi_pkg::ST_START && !dim_reg,
        "query did not start with the strike scan")
    `VGBI_ASSERT(a_weights_bounded,
        (state_reg == vgbi_pkg::ST_CORNER_RD) |->
            (wk_reg <= vgbi_pkg::WONE && wt_reg <= vgbi_pkg::WONE),
        "interpolation weight above one")

endmodule
